### design/ecfsf_pkg.sv
package ecfsf_pkg;

  localparam int STORE_AW = 16;
  localparam int GRID_W   = 9;
  localparam int POS_W    = 32;
  localparam int SIZE_W   = 31;
  localparam int VAL_W    = 8;
  localparam int DIV_W    = 33;
  localparam int CFG_IW   = 3;

  localparam int DEF_MAX_WIDTH     = 256;
  localparam int DEF_MAX_HEIGHT    = 256;
  localparam int DEF_SEARCH_RADIUS = 5;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] RUN_FILTERED = 2'd0;
  localparam logic [1:0] RUN_OUTSIDE  = 2'd1;
  localparam logic [1:0] RUN_NO_SEED  = 2'd2;

  localparam logic REPLY_RUN  = 1'b0;
  localparam logic REPLY_READ = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_WIDTH    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_X = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_SIZE     = 3'd4;

  localparam logic [GRID_W-1:0]       RST_WIDTH     = 9'd256;
  localparam logic [GRID_W-1:0]       RST_HEIGHT    = 9'd256;
  localparam logic [SIZE_W-1:0]       RST_CELL_SIZE = 31'd6554;
  localparam logic signed [VAL_W-1:0] BLOCKED_VALUE = 8'sd100;
  localparam logic [17:0]             STORE_CELLS   = 18'd65536;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ, S_RUN, S_SIZE, S_HDIV, S_XSET, S_XDIV, S_YSET, S_YDIV,
    S_MUL, S_EGO_RD, S_EGO_CHK, S_SR, S_SR_CHK, S_BFS0, S_POP, S_NB, S_NB_CHK,
    S_SW_RD, S_SW_WR
  } state_t;

  typedef enum logic [1:0] {DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT} dir_t;

  typedef struct packed {
    logic [GRID_W-1:0]   row;
    logic [GRID_W-1:0]   col;
    logic [STORE_AW-1:0] idx;
  } qent_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                     valid;
    logic                     reply_kind;
    logic [1:0]               status;
    logic signed [VAL_W-1:0]  value;
  } res_t;

  typedef struct packed {
    logic [GRID_W-1:0]        width;
    logic [GRID_W-1:0]        height;
    logic signed [POS_W-1:0]  base_x;
    logic signed [POS_W-1:0]  base_y;
    logic [SIZE_W-1:0]        size;
  } cfg_t;

endpackage

### design/ecfsf_div.sv
module ecfsf_div import ecfsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]       rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [SIZE_W-1:0] dvs_r;
  logic [32:0]       shifted;
  logic [32:0]       diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = shifted >= {2'b00, dvs_r};
  assign diff    = shifted - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : shifted[31:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### design/ecfsf_core.sv
module ecfsf_core import ecfsf_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int SEARCH_RADIUS = DEF_SEARCH_RADIUS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [1:0]               kind,
  input  logic [STORE_AW-1:0]      cell_index,
  input  logic signed [VAL_W-1:0]  cell_value,
  input  logic signed [POS_W-1:0]  ego_x,
  input  logic signed [POS_W-1:0]  ego_y,
  input  cfg_t                     cfg,
  output logic                     ready,
  output res_t                     res
);

  localparam int DW  = $clog2(SEARCH_RADIUS + 1) + 1;
  localparam int D2W = $clog2(2 * SEARCH_RADIUS * SEARCH_RADIUS + 1);
  localparam logic signed [DW-1:0] R_POS = DW'(SEARCH_RADIUS);
  localparam logic signed [DW-1:0] R_NEG = -R_POS;
  localparam logic [13:0] MW = 14'(MAX_WIDTH);
  localparam logic [13:0] MH = 14'(MAX_HEIGHT);

  state_t state_r, state_nxt;

  logic [8:0] cell_mem [0:(1 << STORE_AW)-1];
  qent_t      q_mem    [0:(1 << STORE_AW)-1];

  logic                mem_we, mem_re;
  logic [STORE_AW-1:0] mem_addr;
  logic [8:0]          mem_wd;
  logic [8:0]          mem_rd_r;
  logic                q_we, q_re;
  logic [STORE_AW-1:0] q_wa, q_ra;
  qent_t               q_wd;
  qent_t               q_rd_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [POS_W-1:0] ex_r, ey_r;
  logic [GRID_W-1:0]   w_r, h_r, col_r, row_r;
  logic [17:0]         prod_r;
  logic [16:0]         total_r;
  logic [STORE_AW-1:0] seed_r, rb_r, clr_r;
  logic signed [DW-1:0] dr_r, dc_r;
  logic [D2W-1:0]      best_r;
  logic                found_r;
  qent_t               fnd_r, nb_r;
  dir_t                dir_r;
  logic [16:0]         head_r, tail_r, sw_r;

  logic [GRID_W-1:0]   wv, hv;
  logic [SIZE_W-1:0]   size_eff;
  logic [DIV_W-1:0]    diff_x, diff_y;
  logic signed [10:0]  sr_nr, sr_nc;
  logic                sr_in, sr_last, sr_hit;
  logic [STORE_AW-1:0] sr_addr;
  logic signed [2*DW-1:0] dr_sq, dc_sq;
  logic [D2W-1:0]      sr_d2;
  logic                nb_ok;
  qent_t               nb;
  logic                cell_free;
  logic [STORE_AW-1:0] rw_off;

  ecfsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign wv = (14'(cfg.width) > MW) ? MW[GRID_W-1:0] : cfg.width;
  assign hv = (14'(cfg.height) > MH) ? MH[GRID_W-1:0] : cfg.height;
  assign size_eff = (cfg.size == '0) ? SIZE_W'(1) : cfg.size;
  assign diff_x = {ex_r[POS_W-1], ex_r} - {cfg.base_x[POS_W-1], cfg.base_x};
  assign diff_y = {ey_r[POS_W-1], ey_r} - {cfg.base_y[POS_W-1], cfg.base_y};

  assign sr_nr   = $signed({2'b00, row_r}) + 11'(dr_r);
  assign sr_nc   = $signed({2'b00, col_r}) + 11'(dc_r);
  assign sr_in   = !sr_nr[10] && (sr_nr < $signed({2'b00, h_r}))
                && !sr_nc[10] && (sr_nc < $signed({2'b00, w_r}));
  assign sr_addr = rb_r + {7'b0, sr_nc[8:0]};
  assign dr_sq   = dr_r * dr_r;
  assign dc_sq   = dc_r * dc_r;
  assign sr_d2   = D2W'(dr_sq) + D2W'(dc_sq);
  assign sr_last = (dc_r == R_POS) && (dr_r == R_POS);
  assign cell_free = (mem_rd_r[7:0] == 8'd0);
  assign sr_hit  = cell_free && (!found_r || (sr_d2 < best_r));
  assign rw_off  = 16'({7'b0, w_r} * 16'(SEARCH_RADIUS));

  always_comb begin
    nb = q_rd_r;
    nb_ok = 1'b0;
    case (dir_r)
      DIR_UP: begin
        nb_ok  = (q_rd_r.row != '0);
        nb.row = q_rd_r.row - 1'b1;
        nb.idx = q_rd_r.idx - {7'b0, w_r};
      end
      DIR_DOWN: begin
        nb_ok  = ({1'b0, q_rd_r.row} + 10'd1) < {1'b0, h_r};
        nb.row = q_rd_r.row + 1'b1;
        nb.idx = q_rd_r.idx + {7'b0, w_r};
      end
      DIR_LEFT: begin
        nb_ok  = (q_rd_r.col != '0);
        nb.col = q_rd_r.col - 1'b1;
        nb.idx = q_rd_r.idx - 1'b1;
      end
      DIR_RIGHT: begin
        nb_ok  = ({1'b0, q_rd_r.col} + 10'd1) < {1'b0, w_r};
        nb.col = q_rd_r.col + 1'b1;
        nb.idx = q_rd_r.idx + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ready     = 1'b0;
    res       = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wd    = '0;
    q_we      = 1'b0;
    q_re      = 1'b0;
    q_wa      = '0;
    q_ra      = '0;
    q_wd      = '0;
    div_req   = '0;
    res.reply_kind = REPLY_RUN;
    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        ready = 1'b1;
        if (go) begin
          case (kind)
            KIND_WRITE: begin
              mem_we   = 1'b1;
              mem_addr = cell_index;
              mem_wd   = {1'b0, cell_value};
            end
            KIND_READ: begin
              mem_re    = 1'b1;
              mem_addr  = cell_index;
              state_nxt = S_READ;
            end
            KIND_RUN: state_nxt = S_RUN;
            default: ;
          endcase
        end
      end
      S_READ: begin
        res.valid      = 1'b1;
        res.reply_kind = REPLY_READ;
        res.value      = mem_rd_r[7:0];
        state_nxt      = S_IDLE;
      end
      S_RUN: begin
        if (wv == '0 || hv == '0) begin
          res.valid  = 1'b1;
          res.status = RUN_OUTSIDE;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        if (prod_r > STORE_CELLS) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(STORE_CELLS);
          div_req.divisor  = SIZE_W'(w_r);
          state_nxt        = S_HDIV;
        end else begin
          state_nxt = S_XSET;
        end
      end
      S_HDIV: begin
        if (div_rsp.done) state_nxt = S_XSET;
      end
      S_XSET: begin
        if (diff_x[DIV_W-1]) begin
          res.valid  = 1'b1;
          res.status = RUN_OUTSIDE;
          state_nxt  = S_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = diff_x;
          div_req.divisor  = size_eff;
          state_nxt        = S_XDIV;
        end
      end
      S_XDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= DIV_W'(w_r)) begin
            res.valid  = 1'b1;
            res.status = RUN_OUTSIDE;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_YSET;
          end
        end
      end
      S_YSET: begin
        if (diff_y[DIV_W-1]) begin
          res.valid  = 1'b1;
          res.status = RUN_OUTSIDE;
          state_nxt  = S_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = diff_y;
          div_req.divisor  = size_eff;
          state_nxt        = S_YDIV;
        end
      end
      S_YDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= DIV_W'(h_r)) begin
            res.valid  = 1'b1;
            res.status = RUN_OUTSIDE;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: state_nxt = S_EGO_RD;
      S_EGO_RD: begin
        mem_re    = 1'b1;
        mem_addr  = seed_r;
        state_nxt = S_EGO_CHK;
      end
      S_EGO_CHK: state_nxt = cell_free ? S_BFS0 : S_SR;
      S_SR: begin
        if (sr_in) begin
          mem_re    = 1'b1;
          mem_addr  = sr_addr;
          state_nxt = S_SR_CHK;
        end else if (sr_last) begin
          if (found_r) begin
            state_nxt = S_BFS0;
          end else begin
            res.valid  = 1'b1;
            res.status = RUN_NO_SEED;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_SR_CHK: begin
        if (!sr_last) begin
          state_nxt = S_SR;
        end else if (found_r || sr_hit) begin
          state_nxt = S_BFS0;
        end else begin
          res.valid  = 1'b1;
          res.status = RUN_NO_SEED;
          state_nxt  = S_IDLE;
        end
      end
      S_BFS0: begin
        q_we      = 1'b1;
        q_wd      = fnd_r;
        mem_we    = 1'b1;
        mem_addr  = fnd_r.idx;
        mem_wd    = 9'h100;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (head_r < tail_r) begin
          q_re      = 1'b1;
          q_ra      = head_r[STORE_AW-1:0];
          state_nxt = S_NB;
        end else begin
          state_nxt = S_SW_RD;
        end
      end
      S_NB: begin
        if (nb_ok) begin
          mem_re    = 1'b1;
          mem_addr  = nb.idx;
          state_nxt = S_NB_CHK;
        end else if (dir_r == DIR_RIGHT) begin
          state_nxt = S_POP;
        end
      end
      S_NB_CHK: begin
        if (!mem_rd_r[8] && cell_free) begin
          mem_we   = 1'b1;
          mem_addr = nb_r.idx;
          mem_wd   = 9'h100;
          q_we     = 1'b1;
          q_wa     = tail_r[STORE_AW-1:0];
          q_wd     = nb_r;
        end
        state_nxt = (dir_r == DIR_RIGHT) ? S_POP : S_NB;
      end
      S_SW_RD: begin
        mem_re    = 1'b1;
        mem_addr  = sw_r[STORE_AW-1:0];
        state_nxt = S_SW_WR;
      end
      S_SW_WR: begin
        mem_we   = 1'b1;
        mem_addr = sw_r[STORE_AW-1:0];
        mem_wd   = {1'b0, (cell_free && !mem_rd_r[8]) ? BLOCKED_VALUE : mem_rd_r[7:0]};
        if (sw_r + 17'd1 == total_r) begin
          res.valid  = 1'b1;
          res.status = RUN_FILTERED;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SW_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == S_BFS0) begin
        head_r <= '0;
        tail_r <= 17'd1;
      end
      if (q_re) head_r <= head_r + 1'b1;
      if (state_r == S_NB_CHK && q_we) tail_r <= tail_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ex_r <= ego_x;
        ey_r <= ego_y;
      end
      S_RUN: begin
        w_r    <= wv;
        h_r    <= hv;
        prod_r <= wv * hv;
      end
      S_HDIV:   if (div_rsp.done) h_r <= div_rsp.quotient[GRID_W-1:0];
      S_XDIV:   col_r <= div_rsp.quotient[GRID_W-1:0];
      S_YDIV:   row_r <= div_rsp.quotient[GRID_W-1:0];
      S_MUL: begin
        total_r <= 17'(w_r * h_r);
        seed_r  <= 16'(row_r * w_r) + {7'b0, col_r};
      end
      S_EGO_RD: begin
        dr_r    <= R_NEG;
        dc_r    <= R_NEG;
        rb_r    <= seed_r - {7'b0, col_r} - rw_off;
        found_r <= 1'b0;
        best_r  <= '0;
        fnd_r   <= '{row: row_r, col: col_r, idx: seed_r};
      end
      S_SR, S_SR_CHK: begin
        if (state_r == S_SR_CHK && sr_hit) begin
          found_r <= 1'b1;
          best_r  <= sr_d2;
          fnd_r   <= '{row: sr_nr[8:0], col: sr_nc[8:0], idx: sr_addr};
        end
        if (state_r == S_SR_CHK || !sr_in) begin
          if (dc_r == R_POS) begin
            dc_r <= R_NEG;
            dr_r <= dr_r + 1'b1;
            rb_r <= rb_r + {7'b0, w_r};
          end else begin
            dc_r <= dc_r + 1'b1;
          end
        end
      end
      S_POP: begin
        dir_r <= DIR_UP;
        sw_r  <= '0;
      end
      S_NB: begin
        nb_r <= nb;
        if (!nb_ok) dir_r <= dir_t'(dir_r + 2'd1);
      end
      S_NB_CHK: dir_r <= dir_t'(dir_r + 2'd1);
      S_SW_WR:  sw_r <= sw_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_addr] <= mem_wd;
    if (mem_re) mem_rd_r <= cell_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_rd_r <= q_mem[q_ra];
  end

endmodule

### design/ego_connected_free_space_filter.sv
// Cell write: no result, and the core stays idle; cell read: the value is registered and the
// reply passes through the output register; the next transaction waits for the read state.
// Run: one division per coordinate (plus one more division for oversized grids), a search of
// the cells around the ego cell, a visit of the neighbours of each reached cell and a final
// sweep of every grid cell, all through the single-port cell memory; the next transaction waits.
// Reset (synchronous, active low) restores the registers, then clears all 65536 cells, visited
// bits and values alike, before the first transaction is taken.
module ego_connected_free_space_filter import ecfsf_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int SEARCH_RADIUS = DEF_SEARCH_RADIUS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic [STORE_AW-1:0]      in_cell_index,
  input  logic signed [VAL_W-1:0]  in_cell_value,
  input  logic signed [POS_W-1:0]  in_ego_x,
  input  logic signed [POS_W-1:0]  in_ego_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_reply_kind,
  output logic [1:0]               out_run_status,
  output logic signed [VAL_W-1:0]  out_read_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [31:0]              cfg_data
);

  cfg_t  cfg_r;
  res_t  core_res;
  logic  core_ready;
  logic  go;
  logic  out_valid_r;
  logic  reply_kind_r;
  logic [1:0] status_r;
  logic signed [VAL_W-1:0] value_r;
  logic  needs_out;

  assign cfg_ready = 1'b1;
  assign needs_out = (in_kind == KIND_READ) || (in_kind == KIND_RUN);
  assign in_stall  = !core_ready || (needs_out && out_valid_r && out_stall);
  assign go        = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= RST_WIDTH;
      cfg_r.height <= RST_HEIGHT;
      cfg_r.base_x <= '0;
      cfg_r.base_y <= '0;
      cfg_r.size   <= RST_CELL_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:    cfg_r.width  <= cfg_data[GRID_W-1:0];
        CFG_HEIGHT:   cfg_r.height <= cfg_data[GRID_W-1:0];
        CFG_ORIGIN_X: cfg_r.base_x <= cfg_data;
        CFG_ORIGIN_Y: cfg_r.base_y <= cfg_data;
        CFG_SIZE:     cfg_r.size   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  ecfsf_core #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .SEARCH_RADIUS (SEARCH_RADIUS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .kind       (in_kind),
    .cell_index (in_cell_index),
    .cell_value (in_cell_value),
    .ego_x      (in_ego_x),
    .ego_y      (in_ego_y),
    .cfg        (cfg_r),
    .ready      (core_ready),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid) begin
      reply_kind_r <= core_res.reply_kind;
      status_r     <= core_res.status;
      value_r      <= core_res.value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = reply_kind_r;
  assign out_run_status = status_r;
  assign out_read_value = value_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    core_res.valid |-> !(out_valid_r && out_stall))
    else $error("result produced while output register held");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (go && in_kind == KIND_READ) |=> (core_res.valid && core_res.reply_kind == REPLY_READ))
    else $error("read reply missing");

  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    (core_res.valid && core_res.reply_kind == REPLY_READ) |-> core_res.status == RUN_FILTERED)
    else $error("read reply carries run status");

endmodule

### tb/tb_ego_connected_free_space_filter.sv
`timescale 1ns / 1ps

module tb_ego_connected_free_space_filter;
  import ecfsf_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic                    reply_kind;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value;
  } reply_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_kind;
  logic [STORE_AW-1:0]     in_cell_index;
  logic signed [VAL_W-1:0] in_cell_value;
  logic signed [POS_W-1:0] in_ego_x;
  logic signed [POS_W-1:0] in_ego_y;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_reply_kind;
  logic [1:0]              out_run_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IW-1:0]       cfg_index;
  logic [31:0]             cfg_data;

  ego_connected_free_space_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_cell_index(in_cell_index), .in_cell_value(in_cell_value),
    .in_ego_x(in_ego_x), .in_ego_y(in_ego_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_reply_kind(out_reply_kind),
    .out_run_status(out_run_status), .out_read_value(out_read_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic signed [VAL_W-1:0] occupancy [65536];
  bit                      written [65536];
  bit                      reached [65536];
  reply_t                  pending_replies[$];

  logic [GRID_W-1:0]       grid_w;
  logic [GRID_W-1:0]       grid_h;
  logic signed [POS_W-1:0] org_x;
  logic signed [POS_W-1:0] org_y;
  logic [SIZE_W-1:0]       cell_len;

  bit calm;
  int errors;
  int items_sent;
  int reads_seen;
  int status_count [4];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("ego_connected_free_space_filter verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= (!calm && $urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected transaction: reply_kind %0d", out_reply_kind);
        errors++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_reply_kind !== exp_r.reply_kind) begin
          $error("reply_kind expected %0d actual %0d", exp_r.reply_kind, out_reply_kind);
          errors++;
        end
        if (out_run_status !== exp_r.status) begin
          $error("run_status expected %0d actual %0d", exp_r.status, out_run_status);
          errors++;
        end
        if (out_read_value !== exp_r.value) begin
          $error("read_value expected %0d actual %0d", exp_r.value, out_read_value);
          errors++;
        end
        if (exp_r.reply_kind == REPLY_READ) reads_seen++;
        else status_count[exp_r.status]++;
      end
    end
  end

  function automatic longint used_width();
    return (grid_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : grid_w;
  endfunction

  function automatic longint used_height();
    longint w, h;
    w = used_width();
    h = (grid_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : grid_h;
    if (w > 0 && w * h > 65536) h = 65536 / w;
    return h;
  endfunction

  function automatic longint used_size();
    return (cell_len == 0) ? 1 : longint'(cell_len);
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic logic [1:0] filter_status(logic signed [31:0] ex, logic signed [31:0] ey);
    longint w, h, total, col, row, seed, best, found, cur, nr, nc, ni, d2;
    int dir_r [4];
    int dir_c [4];
    int frontier[$];
    dir_r = '{-1, 1, 0, 0};
    dir_c = '{0, 0, -1, 1};
    w = used_width();
    h = used_height();
    total = w * h;
    if (total <= 0) return RUN_OUTSIDE;
    col = floor_quot(longint'(ex) - longint'(org_x), used_size());
    row = floor_quot(longint'(ey) - longint'(org_y), used_size());
    if (col < 0 || col >= w || row < 0 || row >= h) return RUN_OUTSIDE;
    seed = row * w + col;
    if (occupancy[seed] != 0) begin
      best = 64'h7fffffffffffffff;
      found = -1;
      for (longint dr = -DEF_SEARCH_RADIUS; dr <= DEF_SEARCH_RADIUS; dr++) begin
        for (longint dc = -DEF_SEARCH_RADIUS; dc <= DEF_SEARCH_RADIUS; dc++) begin
          nr = row + dr;
          nc = col + dc;
          if (nr < 0 || nr >= h || nc < 0 || nc >= w) continue;
          if (occupancy[nr * w + nc] != 0) continue;
          d2 = dr * dr + dc * dc;
          if (d2 < best) begin
            best = d2;
            found = nr * w + nc;
          end
        end
      end
      if (found < 0) return RUN_NO_SEED;
      seed = found;
    end
    for (int i = 0; i < 65536; i++) reached[i] = 0;
    frontier.push_back(int'(seed));
    reached[seed] = 1;
    while (frontier.size() > 0) begin
      cur = frontier.pop_front();
      for (int d = 0; d < 4; d++) begin
        nr = cur / w + dir_r[d];
        nc = cur % w + dir_c[d];
        if (nr < 0 || nr >= h || nc < 0 || nc >= w) continue;
        ni = nr * w + nc;
        if (reached[ni] || occupancy[ni] != 0) continue;
        reached[ni] = 1;
        frontier.push_back(int'(ni));
      end
    end
    for (longint i = 0; i < total; i++)
      if (occupancy[i] == 0 && !reached[i]) occupancy[i] = BLOCKED_VALUE;
    return RUN_FILTERED;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [15:0] idx,
                           input logic signed [7:0] val, input logic signed [31:0] ex,
                           input logic signed [31:0] ey);
    reply_t r;
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_cell_index <= idx;
    in_cell_value <= val;
    in_ego_x      <= ex;
    in_ego_y      <= ey;
    do @(posedge clk); while (in_stall);
    items_sent++;
    case (kind)
      KIND_WRITE: begin
        occupancy[idx] = val;
        written[idx] = 1;
      end
      KIND_RUN: begin
        r.reply_kind = REPLY_RUN;
        r.status = filter_status(ex, ey);
        r.value = '0;
        pending_replies.push_back(r);
      end
      KIND_READ: begin
        r.reply_kind = REPLY_READ;
        r.status = RUN_FILTERED;
        r.value = occupancy[idx];
        pending_replies.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH:    grid_w = data[GRID_W-1:0];
      CFG_HEIGHT:   grid_h = data[GRID_W-1:0];
      CFG_ORIGIN_X: org_x = data;
      CFG_ORIGIN_Y: org_y = data;
      CFG_SIZE:     cell_len = data[SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [8:0] w, input logic [8:0] h, input logic [31:0] ox,
                          input logic [31:0] oy, input logic [30:0] sz);
    drain();
    cfg_write(CFG_WIDTH, {23'($urandom_range(8388607)), w});
    cfg_write(CFG_HEIGHT, {23'($urandom_range(8388607)), h});
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_write(CFG_SIZE, {1'($urandom_range(1)), sz});
  endtask

  function automatic logic signed [7:0] random_occupied();
    logic signed [7:0] v;
    v = 8'($urandom);
    return (v == 0) ? 8'sd1 : v;
  endfunction

  task automatic fill_grid(input int free_pct);
    longint total;
    total = used_width() * used_height();
    for (longint i = 0; i < total; i++)
      send_item(KIND_WRITE, i[15:0], ($urandom_range(99) < free_pct) ? 8'sd0 : random_occupied(),
                $urandom, $urandom);
  endtask

  task automatic run_near_grid();
    longint col, row, ex, ey;
    col = longint'($urandom_range(used_width() + 3)) - 2;
    row = longint'($urandom_range(used_height() + 3)) - 2;
    ex = longint'(org_x) + col * used_size() + $urandom_range(used_size() - 1);
    ey = longint'(org_y) + row * used_size() + $urandom_range(used_size() - 1);
    send_item(KIND_RUN, 16'($urandom), 8'($urandom), ex[31:0], ey[31:0]);
  endtask

  task automatic random_traffic(input int count);
    int pick;
    longint total;
    logic [15:0] idx;
    total = used_width() * used_height();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      idx = 16'($urandom_range(total - 1));
      if (pick < 40) begin
        send_item(KIND_WRITE, idx, ($urandom_range(1) == 0) ? 8'sd0 : random_occupied(),
                  $urandom, $urandom);
      end else if (pick < 45) begin
        send_item(KIND_WRITE, 16'($urandom), 8'($urandom), $urandom, $urandom);
      end else if (pick < 75) begin
        logic [15:0] any;
        any = 16'($urandom);
        send_item(KIND_READ, written[any] ? any : idx, 8'($urandom), $urandom, $urandom);
      end else if (pick < 88) begin
        run_near_grid();
      end else if (pick < 92) begin
        send_item(KIND_RUN, 16'($urandom), 8'($urandom), $urandom, $urandom);
      end else begin
        send_item(KIND_UNUSED, 16'($urandom), 8'($urandom), $urandom, $urandom);
      end
    end
  endtask

  task automatic test_directed();
    send_item(KIND_WRITE, 16'd0, 8'sh80, 32'sd0, 32'sd0);
    send_item(KIND_WRITE, 16'hffff, 8'sd127, -32'sd1, -32'sd1);
    send_item(KIND_READ, 16'd0, 8'sd0, 32'sd0, 32'sd0);
    send_item(KIND_READ, 16'hffff, 8'sd0, 32'sd0, 32'sd0);
    send_item(KIND_UNUSED, 16'hffff, -8'sd1, 32'h7fffffff, 32'h80000000);
    send_item(KIND_RUN, 16'd0, 8'sd0, 32'h80000000, 32'sd0);
    send_item(KIND_RUN, 16'd0, 8'sd0, 32'sd0, 32'h80000000);
    set_grid(9'd0, 9'd4, 32'd0, 32'd0, 31'd65536);
    send_item(KIND_RUN, 16'd0, 8'sd0, 32'sd0, 32'sd0);
    set_grid(9'd4, 9'd4, 32'd0, 32'd0, 31'd65536);
    for (int i = 0; i < 16; i++)
      send_item(KIND_WRITE, i[15:0], (i == 6) ? 8'sd0 : 8'sd50, 32'sd0, 32'sd0);
    send_item(KIND_RUN, 16'd0, 8'sd0, 32'sd0, 32'sd0);
    send_item(KIND_WRITE, 16'd6, 8'sd9, 32'sd0, 32'sd0);
    send_item(KIND_RUN, 16'd0, 8'sd0, 32'sd65536, 32'sd65536);
    send_item(KIND_WRITE, 16'd0, 8'sd0, 32'sd0, 32'sd0);
    send_item(KIND_WRITE, 16'd15, 8'sd0, 32'sd0, 32'sd0);
    send_item(KIND_RUN, 16'd0, 8'sd0, 32'sd65536, 32'sd65536);
    send_item(KIND_READ, 16'd15, 8'sd0, 32'sd0, 32'sd0);
    send_item(KIND_RUN, 16'd0, 8'sd0, 32'sd262144, 32'sd0);
  endtask

  task automatic test_config_extremes();
    set_grid(9'd256, 9'd1, 32'd0, 32'd0, 31'd1);
    fill_grid(70);
    random_traffic(30);
    set_grid(9'd1, 9'd256, 32'hffff0000, 32'd0, 31'd65536);
    fill_grid(70);
    random_traffic(30);
    set_grid(9'd511, 9'd1, 32'd0, 32'd0, 31'd100);
    random_traffic(20);
    set_grid(9'd12, 9'd10, 32'h80000000, 32'h7fffffff, 31'd1);
    fill_grid(60);
    random_traffic(40);
    set_grid(9'd10, 9'd12, $urandom, $urandom, 31'h7fffffff);
    fill_grid(60);
    random_traffic(40);
    set_grid(9'd6, 9'd6, 32'd0, 32'd0, 31'd0);
    fill_grid(50);
    random_traffic(40);
  endtask

  task automatic test_random_grids();
    int phase;
    phase = 0;
    while (items_sent < 1250) begin
      calm = (phase == 1);
      set_grid(9'($urandom_range(14, 1)), 9'($urandom_range(14, 1)), $urandom, $urandom,
               31'($urandom_range(200000, 1)));
      fill_grid($urandom_range(90, 30));
      random_traffic(60);
      phase++;
    end
    calm = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_WRITE;
    in_cell_index <= '0;
    in_cell_value <= '0;
    in_ego_x <= '0;
    in_ego_y <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_data <= '0;
    grid_w = RST_WIDTH;
    grid_h = RST_HEIGHT;
    org_x = '0;
    org_y = '0;
    cell_len = RST_CELL_SIZE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random_grids();
    drain();
    $display("covered %0d input items, %0d reads, runs: %0d filtered, %0d outside, %0d no seed",
             items_sent, reads_seen, status_count[RUN_FILTERED], status_count[RUN_OUTSIDE],
             status_count[RUN_NO_SEED]);
    if (errors == 0) $display("ego_connected_free_space_filter verification clean");
    else $display("ego_connected_free_space_filter verification failed");
    $finish;
  end

endmodule
